// File: hdl/dual_axis_pid_motor_drive_assert.svh
// Assertion macros used by the dual-axis drive top level.
`ifndef DUAL_AXIS_PID_MOTOR_DRIVE_ASSERT_SVH
`define DUAL_AXIS_PID_MOTOR_DRIVE_ASSERT_SVH
`ifndef SYNTHESIS
`define DAPMD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dapmd assertion failed");
`define DAPMD_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("dapmd sequence assertion failed");
`else
`define DAPMD_ASSERT(lbl, prop)
`define DAPMD_ASSERT_NEXT(lbl, cond, conseq)
`endif
`endif

// File: hdl/dapmd_pkg.sv
// Types and constants for the dual-axis PID motor drive.
package dapmd_pkg;
    localparam int POSITION_BITS = 24;
    localparam int ERR_W         = POSITION_BITS + 1;
    localparam int DE_W          = POSITION_BITS + 2;
    localparam int SUM_BITS      = 48;
    localparam int GAIN_W        = 24;
    localparam int GAIN_FRAC     = 16;
    localparam int DRIVE_LIMIT   = 255;
    localparam int DRIVE_W       = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam int MAG_W         = 8;
    localparam int TIME_W        = 32;
    localparam int MICRO         = 1000000;
    localparam int MICRO_W       = 20;
    localparam int NUM_W         = 72;
    localparam int DEN_W         = 32;
    localparam int CNT_W         = $clog2(NUM_W + 1);
    localparam int TERM_W        = 60;
    localparam int TOT_W         = 64;
    localparam int CFG_W         = 3;

    localparam logic [CFG_W-1:0] CFG_PAN_KP  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_PAN_KD  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_PAN_KI  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_TILT_KP = 3'd3;
    localparam logic [CFG_W-1:0] CFG_TILT_KD = 3'd4;
    localparam logic [CFG_W-1:0] CFG_TILT_KI = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_DIV, S_SUM, S_DONE
    } t_lane_state;

    typedef struct packed {
        logic [TIME_W-1:0]               now_us;
        logic signed [POSITION_BITS-1:0] pan_position;
        logic signed [POSITION_BITS-1:0] tilt_position;
        logic signed [POSITION_BITS-1:0] pan_setpoint;
        logic signed [POSITION_BITS-1:0] tilt_setpoint_cmd;
    } t_in_beat;

    typedef struct packed {
        logic             pan_forward;
        logic [MAG_W-1:0] pan_magnitude;
        logic             tilt_forward;
        logic [MAG_W-1:0] tilt_magnitude;
    } t_out_beat;

    typedef struct packed {
        logic                      done;
        logic signed [DRIVE_W-1:0] drive;
    } t_lane_res;
endpackage

// File: hdl/dapmd_div.sv
// Restoring divider, one quotient bit per cycle.
module dapmd_div import dapmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             fits;

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, r_den};
    assign fits   = !diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// File: hdl/dapmd_lane.sv
// One axis of the PID: error state, integral, gain terms and drive.
module dapmd_lane import dapmd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_take,
    input  logic signed [ERR_W-1:0] i_err,
    input  logic [TIME_W-1:0]       i_dt,
    input  logic [GAIN_W-1:0]       i_kp,
    input  logic [GAIN_W-1:0]       i_kd,
    input  logic [GAIN_W-1:0]       i_ki,
    output t_lane_res               o_res
);
    localparam int INC_W  = ERR_W + TIME_W;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int DEM_W  = DE_W + MICRO_W;
    localparam int DEM_LO = DEM_W / 2;
    localparam int DL_W   = GAIN_W + DEM_W - DEM_LO;
    localparam int SUM_LO = SUM_BITS / 2;
    localparam int IL_W   = GAIN_W + SUM_BITS - SUM_LO;
    localparam int SW_W   = SUM_BITS + 2;
    localparam int IQ_SH  = 6;
    localparam int SH_W   = NUM_W - 1 - IQ_SH;
    localparam int HALF_W = 33;
    localparam int RCP_W  = 66;
    localparam int PP_W   = 2 * HALF_W;
    localparam int PROD_W = SH_W + RCP_W;
    localparam int RCP_SH = 79;
    localparam int IQ_W   = PROD_W - RCP_SH;
    localparam logic [RCP_W-1:0] RCP_M = 66'd38685626227668133591;
    localparam logic [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SW_W-1:0] SW_HI = {2'b0, SUM_HI};
    localparam logic signed [SW_W-1:0] SW_LO = ~SW_HI;
    localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};
    localparam logic signed [TOT_W-1:0] DRV_HI =
        TOT_W'((DRIVE_LIMIT + 1) * (2 ** GAIN_FRAC));
    localparam logic signed [TOT_W-1:0] DRV_LO =
        TOT_W'(-(DRIVE_LIMIT * (2 ** GAIN_FRAC)));

    t_lane_state r_state, n_state;

    logic signed [ERR_W-1:0]    r_last;
    logic signed [DE_W-1:0]     r_de;
    logic signed [SUM_BITS-1:0] r_sum;
    logic [INC_W-1:0]           r_inc;
    logic [P_W-1:0]             r_p;
    logic [DEM_W-1:0]           r_dem;
    logic [DL_W-1:0]            r_dlo, r_dhi;
    logic [IL_W-1:0]            r_ilo, r_ihi;
    logic [PP_W-1:0]            r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [IQ_W-1:0]            r_iquo;
    logic signed [DRIVE_W-1:0]  r_drive;

    logic [ERR_W-1:0]           abs_e;
    logic [DE_W-1:0]            abs_de;
    logic [SUM_BITS-1:0]        abs_sum;
    logic [SUM_BITS-2:0]        inc_mag;
    logic signed [SW_W-1:0]     inc_s, sum_wide;
    logic signed [SUM_BITS-1:0] sum_next;
    logic [NUM_W-1:0]           d_num, integ_num, d_quo;
    logic [SH_W-1:0]            integ_sh;
    logic [PROD_W-1:0]          rcp_prod;
    logic                       d_busy, d_start;
    logic                       dt_zero;
    logic [TERM_W-1:0]          d_mag, i_mag;
    logic signed [TOT_W-1:0]    p_s, d_s, i_s, total, shifted;
    logic signed [DRIVE_W-1:0]  drive;

    assign dt_zero = (i_dt == '0);
    assign abs_e   = i_err[ERR_W-1] ? ERR_W'(-i_err) : ERR_W'(i_err);
    assign abs_de  = r_de[DE_W-1] ? DE_W'(-r_de) : DE_W'(r_de);
    assign abs_sum = r_sum[SUM_BITS-1] ? SUM_BITS'(-r_sum) : SUM_BITS'(r_sum);

    // Saturate the increment, then add it with saturation.
    always_comb begin
        inc_mag  = (r_inc > INC_W'(SUM_HI)) ? SUM_HI[SUM_BITS-2:0]
                                            : r_inc[SUM_BITS-2:0];
        inc_s    = i_err[ERR_W-1] ? -$signed({3'b0, inc_mag}) : $signed({3'b0, inc_mag});
        sum_wide = $signed({{2{r_sum[SUM_BITS-1]}}, r_sum}) + inc_s;
        if (sum_wide > SW_HI) begin
            sum_next = SW_HI[SUM_BITS-1:0];
        end else if (sum_wide < SW_LO) begin
            sum_next = SW_LO[SUM_BITS-1:0];
        end else begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    assign d_num     = NUM_W'(r_dlo) + (NUM_W'(r_dhi) << DEM_LO);
    assign integ_num = NUM_W'(r_ilo) + (NUM_W'(r_ihi) << SUM_LO);
    assign integ_sh  = integ_num[NUM_W-2:IQ_SH];

    // Integral divide by 10^6: drop the factor 64, then multiply by the
    // rounded-up reciprocal of 15625 and keep the bits above 2^79.
    assign rcp_prod = (PROD_W'(r_pp_ll) + (PROD_W'(r_pp_hh) << (2 * HALF_W)))
                      + ((PROD_W'(r_pp_lh) + PROD_W'(r_pp_hl)) << HALF_W);

    dapmd_div u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (i_dt),
        .o_busy  (d_busy),
        .o_quo   (d_quo)
    );

    // Combine the three terms and floor-clamp the drive.
    always_comb begin
        d_mag   = dt_zero ? '0 : ((d_quo > NUM_W'(TERM_CAP)) ? TERM_CAP
                                                             : d_quo[TERM_W-1:0]);
        i_mag   = TERM_W'(r_iquo);
        p_s     = i_err[ERR_W-1] ? -$signed(TOT_W'(r_p)) : $signed(TOT_W'(r_p));
        d_s     = r_de[DE_W-1] ? -$signed(TOT_W'(d_mag)) : $signed(TOT_W'(d_mag));
        i_s     = r_sum[SUM_BITS-1] ? -$signed(TOT_W'(i_mag)) : $signed(TOT_W'(i_mag));
        total   = p_s + d_s + i_s;
        shifted = total >>> GAIN_FRAC;
        if (total >= DRV_HI) begin
            drive = DRIVE_W'(DRIVE_LIMIT);
        end else if (total < DRV_LO) begin
            drive = DRIVE_W'(-DRIVE_LIMIT);
        end else begin
            drive = shifted[DRIVE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_MUL4;
            S_MUL4:  n_state = S_DIV;
            S_DIV:   if (!d_busy) n_state = S_SUM;
            S_SUM:   n_state = S_DONE;
            S_DONE:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        d_start = 1'b0;
        case (r_state)
            S_MUL3:  d_start = !dt_zero;
            default: d_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_last <= i_err;
            end
            if (r_state == S_MUL2) begin
                r_sum <= sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_de <= $signed({i_err[ERR_W-1], i_err}) - $signed({r_last[ERR_W-1], r_last});
            end
            S_MUL1: begin
                r_inc <= INC_W'(abs_e) * INC_W'(i_dt);
                r_p   <= P_W'(i_kp) * P_W'(abs_e);
                r_dem <= DEM_W'(abs_de) * DEM_W'(MICRO);
            end
            S_MUL2: begin
                r_dlo <= DL_W'(i_kd) * DL_W'(r_dem[DEM_LO-1:0]);
                r_dhi <= DL_W'(i_kd) * DL_W'(r_dem[DEM_W-1:DEM_LO]);
            end
            S_MUL3: begin
                r_ilo <= IL_W'(i_ki) * IL_W'(abs_sum[SUM_LO-1:0]);
                r_ihi <= IL_W'(i_ki) * IL_W'(abs_sum[SUM_BITS-1:SUM_LO]);
            end
            S_MUL4: begin
                r_pp_ll <= PP_W'(integ_sh[HALF_W-1:0]) * PP_W'(RCP_M[HALF_W-1:0]);
                r_pp_lh <= PP_W'(integ_sh[HALF_W-1:0]) * PP_W'(RCP_M[RCP_W-1:HALF_W]);
                r_pp_hl <= PP_W'(integ_sh[SH_W-1:HALF_W]) * PP_W'(RCP_M[HALF_W-1:0]);
                r_pp_hh <= PP_W'(integ_sh[SH_W-1:HALF_W]) * PP_W'(RCP_M[RCP_W-1:HALF_W]);
            end
            S_DIV: begin
                r_iquo <= rcp_prod[PROD_W-1:RCP_SH];
            end
            S_SUM: begin
                r_drive <= drive;
            end
            default: begin
                r_drive <= r_drive;
            end
        endcase
    end

    assign o_res.done  = (r_state == S_DONE);
    assign o_res.drive = r_drive;
endmodule

// File: hdl/dual_axis_pid_motor_drive.sv
// Top level: gain registers, sample capture, two axis lanes and output merge.
//  channel  | handshake                 | payload
//  in       | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//  out      | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//  cfg      | i_cfg_we                  | i_cfg_idx, i_cfg_data
// A beat's result leaves the lanes after the divide; the next beat is taken once the lanes hand it
// to the output register, so the 72-step divide by the interval paces the beats.
// A zero interval skips that divide.
// Both axes run in parallel lanes and finish together.
// Reset is synchronous; the last timestamp, error history and integral clear to zero, gains to defaults.
// A new beat is taken while the previous result waits in the output register;
// a stalled output holds the next result in the lanes and stalls the input.
`include "dual_axis_pid_motor_drive_assert.svh"
module dual_axis_pid_motor_drive import dapmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_idx,
    input  logic [GAIN_W-1:0] i_cfg_data
);
    logic [GAIN_W-1:0]       r_pan_kp, r_pan_kd, r_pan_ki;
    logic [GAIN_W-1:0]       r_tilt_kp, r_tilt_kd, r_tilt_ki;
    logic [TIME_W-1:0]       r_last_time, r_dt;
    logic signed [ERR_W-1:0] r_pan_err, r_tilt_err;
    logic                    r_busy, r_start, r_out_valid;
    t_out_beat               r_out;
    t_lane_res               pan_res, tilt_res;
    logic                    accept, take;

    assign o_in_stall = r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign take       = pan_res.done && tilt_res.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_kp  <= GAIN_W'(98304);
            r_pan_kd  <= GAIN_W'(98304);
            r_pan_ki  <= GAIN_W'(983);
            r_tilt_kp <= GAIN_W'(78643);
            r_tilt_kd <= '0;
            r_tilt_ki <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAN_KP:  r_pan_kp  <= i_cfg_data;
                CFG_PAN_KD:  r_pan_kd  <= i_cfg_data;
                CFG_PAN_KI:  r_pan_ki  <= i_cfg_data;
                CFG_TILT_KP: r_tilt_kp <= i_cfg_data;
                CFG_TILT_KD: r_tilt_kd <= i_cfg_data;
                CFG_TILT_KI: r_tilt_ki <= i_cfg_data;
                default:     r_pan_kp  <= r_pan_kp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy      <= 1'b1;
                r_last_time <= i_in_data.now_us;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the interval and both errors; tilt target arrives negated.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dt       <= i_in_data.now_us - r_last_time;
            r_pan_err  <= ERR_W'(i_in_data.pan_position) - ERR_W'(i_in_data.pan_setpoint);
            r_tilt_err <= ERR_W'(i_in_data.tilt_position)
                          + ERR_W'(i_in_data.tilt_setpoint_cmd);
        end
        if (take) begin
            r_out.pan_forward    <= !pan_res.drive[DRIVE_W-1] && (pan_res.drive != '0);
            r_out.pan_magnitude  <= pan_res.drive[DRIVE_W-1]
                                    ? MAG_W'(-pan_res.drive) : MAG_W'(pan_res.drive);
            r_out.tilt_forward   <= !tilt_res.drive[DRIVE_W-1] && (tilt_res.drive != '0);
            r_out.tilt_magnitude <= tilt_res.drive[DRIVE_W-1]
                                    ? MAG_W'(-tilt_res.drive) : MAG_W'(tilt_res.drive);
        end
    end

    dapmd_lane u_pan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_take  (take),
        .i_err   (r_pan_err),
        .i_dt    (r_dt),
        .i_kp    (r_pan_kp),
        .i_kd    (r_pan_kd),
        .i_ki    (r_pan_ki),
        .o_res   (pan_res)
    );

    dapmd_lane u_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_take  (take),
        .i_err   (r_tilt_err),
        .i_dt    (r_dt),
        .i_kp    (r_tilt_kp),
        .i_kd    (r_tilt_kd),
        .i_ki    (r_tilt_ki),
        .o_res   (tilt_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DAPMD_ASSERT(a_lanes_in_step, pan_res.done == tilt_res.done)
    `DAPMD_ASSERT_NEXT(a_accept_busy, accept, r_busy && r_start)
    `DAPMD_ASSERT_NEXT(a_take_loads, take, r_out_valid && !r_busy)
    `DAPMD_ASSERT(a_done_only_busy, !pan_res.done || r_busy)
endmodule

// File: sim/testbench.sv
// Self-checking testbench for the dual-axis PID motor drive.
`timescale 1ns / 1ps
module testbench;
    import dapmd_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  HOLD_CYCLES = 400;
    localparam longint DRIVE_CAP = 255;
    localparam logic [CFG_W-1:0] CFG_NONE_LO = 3'd6;
    localparam logic [CFG_W-1:0] CFG_NONE_HI = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_beat         o_out_data;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_idx;
    logic [GAIN_W-1:0] i_cfg_data;

    dual_axis_pid_motor_drive dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: gains and per-axis history.
    logic [GAIN_W-1:0] gain_reg [0:5];
    logic [31:0]       prev_time_us;
    longint            pan_prev_err, pan_integ, tilt_prev_err, tilt_integ;

    t_out_beat drive_queue[$];
    int        fail_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_request;
    int        hold_left;
    logic [31:0] stim_time;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stall, with an optional long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Result beat is taken at the next rising edge; values are stable at the falling one.
    always @(negedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_queue.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = drive_queue.pop_front();
                if (o_out_data.pan_forward !== want.pan_forward)
                    report_mismatch("pan_forward", o_out_data.pan_forward, want.pan_forward);
                if (o_out_data.pan_magnitude !== want.pan_magnitude)
                    report_mismatch("pan_magnitude", o_out_data.pan_magnitude,
                                    want.pan_magnitude);
                if (o_out_data.tilt_forward !== want.tilt_forward)
                    report_mismatch("tilt_forward", o_out_data.tilt_forward, want.tilt_forward);
                if (o_out_data.tilt_magnitude !== want.tilt_magnitude)
                    report_mismatch("tilt_magnitude", o_out_data.tilt_magnitude,
                                    want.tilt_magnitude);
            end
        end
    end

    function automatic logic signed [127:0] mag128(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // floor(k * n / d), capped at the term limit
    function automatic logic signed [127:0] capped_quot(input logic signed [127:0] k,
                                                        input logic signed [127:0] n,
                                                        input logic signed [127:0] d);
        logic signed [127:0] cap, q;
        cap = (128'sd1 <<< 60) - 1;
        q = (k * n) / d;
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint axis_drive(input longint pos, input longint tgt,
                                          input logic [GAIN_W-1:0] kp,
                                          input logic [GAIN_W-1:0] kd,
                                          input logic [GAIN_W-1:0] ki,
                                          input logic [31:0] dt,
                                          inout longint prev_err, inout longint integ);
        logic signed [127:0] hi, lo, e, de, inc, s, pt, dterm, it, total, dts, micro;
        hi = (128'sd1 <<< (SUM_BITS - 1)) - 1;
        lo = -hi - 1;
        micro = MICRO;
        dts = {96'b0, dt};
        e = pos - tgt;
        de = e - prev_err;
        inc = mag128(e) * dts;
        if (inc > hi) inc = hi;
        if (e < 0) inc = -inc;
        s = integ + inc;
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        integ = longint'(s);
        pt = capped_quot({104'b0, kp}, mag128(e), 1);
        if (e < 0) pt = -pt;
        if (dt == 0) begin
            dterm = 0;
        end else begin
            dterm = capped_quot({104'b0, kd}, mag128(de) * micro, dts);
            if (de < 0) dterm = -dterm;
        end
        it = capped_quot({104'b0, ki}, mag128(s), micro);
        if (s < 0) it = -it;
        prev_err = longint'(e);
        total = pt + dterm + it;
        if (total >= ((DRIVE_CAP + 1) <<< GAIN_FRAC)) return DRIVE_CAP;
        if (total < -(DRIVE_CAP <<< GAIN_FRAC)) return -DRIVE_CAP;
        return longint'(total >>> GAIN_FRAC);
    endfunction

    function automatic t_out_beat predict_drive(input t_in_beat b);
        t_out_beat r;
        logic [31:0] dt;
        longint pd, td;
        dt = b.now_us - prev_time_us;
        prev_time_us = b.now_us;
        pd = axis_drive(longint'(b.pan_position), longint'(b.pan_setpoint),
                        gain_reg[0], gain_reg[1], gain_reg[2], dt, pan_prev_err, pan_integ);
        td = axis_drive(longint'(b.tilt_position), -longint'(b.tilt_setpoint_cmd),
                        gain_reg[3], gain_reg[4], gain_reg[5], dt, tilt_prev_err, tilt_integ);
        r.pan_forward    = (pd > 0);
        r.pan_magnitude  = MAG_W'((pd < 0) ? -pd : pd);
        r.tilt_forward   = (td > 0);
        r.tilt_magnitude = MAG_W'((td < 0) ? -td : td);
        return r;
    endfunction

    // Called right after a rising edge; returns at the edge that took the beat.
    task automatic send_sample(input t_in_beat b);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        drive_queue.push_back(predict_drive(b));
        stim_time = b.now_us;
    endtask

    task automatic sample_of(input logic [31:0] t, input logic [23:0] pp,
                             input logic [23:0] tp, input logic [23:0] ps,
                             input logic [23:0] tc);
        t_in_beat b;
        b.now_us = t;
        b.pan_position = pp;
        b.tilt_position = tp;
        b.pan_setpoint = ps;
        b.tilt_setpoint_cmd = tc;
        send_sample(b);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_W-1:0] idx, input logic [GAIN_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx <= CFG_TILT_KI) gain_reg[idx] = val;
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_gains(input logic [GAIN_W-1:0] v0, input logic [GAIN_W-1:0] v1,
                                   input logic [GAIN_W-1:0] v2, input logic [GAIN_W-1:0] v3,
                                   input logic [GAIN_W-1:0] v4, input logic [GAIN_W-1:0] v5);
        wait_drained();
        write_gain(CFG_PAN_KP, v0);
        write_gain(CFG_PAN_KD, v1);
        write_gain(CFG_PAN_KI, v2);
        write_gain(CFG_TILT_KP, v3);
        write_gain(CFG_TILT_KD, v4);
        write_gain(CFG_TILT_KI, v5);
    endtask

    function automatic logic [23:0] legal_tilt_cmd(input logic [23:0] v);
        return (v == 24'h800000) ? 24'h800001 : v;
    endfunction

    task automatic send_random_sample();
        logic [31:0] t;
        logic [23:0] pp, tp, ps, tc;
        case ($urandom_range(9))
            0: t = $urandom;
            1: t = stim_time;
            default: t = stim_time + $urandom_range(1, 2000);
        endcase
        ps = 24'($urandom);
        tc = legal_tilt_cmd(24'($urandom));
        if ($urandom_range(3) == 0) begin
            pp = 24'($urandom);
            tp = 24'($urandom);
        end else begin
            pp = ps + 24'($urandom_range(0, 1000)) - 24'd500;
            tp = -tc + 24'($urandom_range(0, 1000)) - 24'd500;
        end
        sample_of(t, pp, tp, ps, tc);
    endtask

    task automatic test_directed();
        // first tick at time zero: zero interval
        sample_of(32'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        sample_of(32'd0, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        sample_of(32'd100, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800001);
        sample_of(32'd100, 24'h000010, 24'hFFFFF0, 24'h000000, 24'h000000);
        // timestamp wrap
        sample_of(32'hFFFFFFF0, 24'd5, 24'd5, 24'd3, 24'hFFFFFD);
        sample_of(32'h00000010, 24'd5, 24'd5, 24'd3, 24'hFFFFFD);
        // integral saturation from a huge interval and error
        sample_of(32'h7FFFFFF0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        sample_of(32'hFFFFFFE0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        sample_of(32'h7FFFFFD0, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800001);
        sample_of(32'hFFFFFFC0, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800001);
        sample_of(32'hFFFFFFC1, 24'd1, 24'd1, 24'd0, 24'hFFFFFF);
        sample_of(32'hFFFFFFC2, 24'd0, 24'd0, 24'd0, 24'd0);
        sample_of(32'h00001000, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd1);
        stim_time = 32'h00001000;
    endtask

    task automatic test_gain_extremes();
        int i;
        write_all_gains(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        for (i = 0; i < 30; i++) send_random_sample();
        write_all_gains(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        // zero drive everywhere
        for (i = 0; i < 10; i++) send_random_sample();
        write_all_gains(24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
        for (i = 0; i < 20; i++) send_random_sample();
        // unknown register indexes: ignored
        wait_drained();
        write_gain(CFG_NONE_LO, 24'($urandom));
        write_gain(CFG_NONE_HI, 24'($urandom));
        for (i = 0; i < 10; i++) send_random_sample();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int i;
        write_all_gains(24'($urandom_range(0, 1 << 19)), 24'($urandom_range(0, 1 << 12)),
                        24'($urandom_range(0, 1 << 12)), 24'($urandom_range(0, 1 << 19)),
                        24'($urandom_range(0, 1 << 12)), 24'($urandom_range(0, 1 << 12)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < count; i++) begin
            // plain stretches with no idling now and then
            if (i % 60 == 40) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (i % 60 == 0) begin
                send_idle_pct  = idle_pct;
                recv_stall_pct = stall_pct;
            end
            send_random_sample();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        int i;
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (i = 0; i < 30; i++) send_random_sample();
        // pause until every result is back, then resume
        wait_drained();
        for (i = 0; i < 10; i++) send_random_sample();
    endtask

    initial begin
        int k;
        fail_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        stim_time      = 32'd0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        gain_reg[0] = 24'd98304;
        gain_reg[1] = 24'd98304;
        gain_reg[2] = 24'd983;
        gain_reg[3] = 24'd78643;
        gain_reg[4] = 24'd0;
        gain_reg[5] = 24'd0;
        prev_time_us  = 32'd0;
        pan_prev_err  = 0;
        pan_integ     = 0;
        tilt_prev_err = 0;
        tilt_integ    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_gain_extremes();
        test_random_phase(0, 0, 250);
        test_random_phase(54, 0, 250);
        test_random_phase(0, 54, 250);
        test_random_phase(8, 8, 250);
        test_backpressure();

        wait_drained();
        repeat (200) @(posedge i_clk);
        k = drive_queue.size();
        if (k != 0) report_mismatch("results left over", 0, k);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/dapmd_pkg.sv
hdl/dapmd_div.sv
hdl/dapmd_lane.sv
hdl/dual_axis_pid_motor_drive.sv
sim/testbench.sv
